// ===== rtl/core/pisc_pkg.sv =====
`default_nettype none

package pisc_pkg;

   localparam int DRIVE_W    = 16;
   localparam int SPEED_W    = 16;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int OPCODE_W   = 3;
   localparam int SUM_W      = 24;
   localparam int TORQUE_W   = 8;

   localparam logic signed [DRIVE_W-1:0] DRIVE_FULL = 16'sd16384;

   localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_READY    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_STATE    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TARGET   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_MEASURED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KICKIN_SPEED     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RESET_SPEED      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_STEP         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INSPECTION_DRIVE = 3'd6;

   localparam logic [15:0] PROP_GAIN_RST        = 16'd205;
   localparam logic [14:0] MAX_STEP_RST         = 15'd82;
   localparam logic [15:0] INSPECTION_DRIVE_RST = 16'd1802;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [SPEED_W-1:0] speed_value;
      logic                      go_ahead;
      logic                      is_driving;
      logic                      is_inspection;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0]  drive_value;
      logic signed [TORQUE_W-1:0] torque_percent;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/pi_speed_controller.sv =====
`default_nettype none

// Channel   Handshake              Payload
// req       req_valid/req_stall    pisc_pkg::req_type (event or tick item)
// rsp       rsp_valid/rsp_stall    pisc_pkg::rsp_type (drive and torque)
// csr       csr_write_en           csr_index, csr_wdata (write only)
//
// One item per cycle while the result is not stalled: an input register, one pass of compute, a result register.
// A tick item that yields a result goes through the input register and then the result register;
// the loop through error_sum_ff and last_drive_ff closes in that single pass.
// Synchronous reset loads register defaults and clears all controller state.
// A stalled result holds the pass; req_stall rises only when both stages are full.

module pi_speed_controller (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire pisc_pkg::req_type              req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      pisc_pkg::rsp_type              rsp_data,
   input  wire logic                           csr_write_en,
   input  wire logic [pisc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pisc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pisc_pkg::*;

   logic [15:0]        prop_gain_ff;
   logic [15:0]        integ_gain_ff;
   logic [SUM_W-1:0]   integral_limit_ff;
   logic [14:0]        kickin_speed_ff;
   logic [14:0]        reset_speed_ff;
   logic [14:0]        max_step_ff;
   logic signed [15:0] inspection_drive_ff;

   logic                      ready_flag_ff;
   logic                      motors_on_ff;
   logic                      inspection_mode_ff;
   logic signed [SPEED_W-1:0] target_speed_ff;
   logic signed [SPEED_W-1:0] measured_speed_ff;
   logic                      have_target_ff;
   logic                      have_measured_ff;
   logic [SUM_W-1:0]          error_sum_ff;
   logic signed [DRIVE_W-1:0] last_drive_ff;

   req_type                   item_ff;
   logic                      item_valid_ff;
   logic                      rsp_valid_ff;
   logic signed [DRIVE_W-1:0] rsp_drive_ff;

   logic advance;
   logic fire;
   logic tick_go;

   logic signed [16:0]        err;
   logic signed [25:0]        sum_raw;
   logic [SUM_W-1:0]          error_sum_in;
   logic signed [32:0]        p_prod;
   logic [39:0]               i_prod;
   logic signed [41:0]        acc;
   logic signed [35:0]        drive_raw;
   logic signed [17:0]        step_lim;
   logic signed [35:0]        drive_lim;
   logic signed [DRIVE_W-1:0] drive_sat;
   logic signed [DRIVE_W-1:0] insp_sat;
   logic signed [DRIVE_W-1:0] last_drive_in;
   logic signed [22:0]        torque_prod;
   logic signed [22:0]        torque_adj;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid_ff && advance;
   assign req_stall = item_valid_ff && !advance;
   assign tick_go   = (item_ff.opcode == OP_TICK) && motors_on_ff
                      && have_target_ff && have_measured_ff;

   always_comb begin
      err     = {target_speed_ff[15], target_speed_ff}
                - {measured_speed_ff[15], measured_speed_ff};
      sum_raw = $signed({2'b00, error_sum_ff}) + $signed({{9{err[16]}}, err});
      if (sum_raw < 26'sd0) begin
         error_sum_in = '0;
      end else if (sum_raw > $signed({2'b00, integral_limit_ff})) begin
         error_sum_in = integral_limit_ff;
      end else begin
         error_sum_in = sum_raw[SUM_W-1:0];
      end
      if (measured_speed_ff < $signed({1'b0, reset_speed_ff})) begin
         error_sum_in = '0;
      end

      p_prod = $signed({1'b0, prop_gain_ff}) * err;
      i_prod = integ_gain_ff * error_sum_in;
      acc    = $signed({{9{p_prod[32]}}, p_prod}) + 42'sd32;
      if (measured_speed_ff > $signed({1'b0, kickin_speed_ff})) begin
         acc = acc + $signed({2'b00, i_prod});
      end
      drive_raw = acc[41:6];

      step_lim = $signed({{2{last_drive_ff[15]}}, last_drive_ff})
                 + $signed({3'b000, max_step_ff});
      if (drive_raw > $signed({{18{step_lim[17]}}, step_lim})) begin
         drive_lim = $signed({{18{step_lim[17]}}, step_lim});
      end else begin
         drive_lim = drive_raw;
      end

      if (drive_lim > $signed({{20{DRIVE_FULL[15]}}, DRIVE_FULL})) begin
         drive_sat = DRIVE_FULL;
      end else if (drive_lim < -$signed({{20{DRIVE_FULL[15]}}, DRIVE_FULL})) begin
         drive_sat = -DRIVE_FULL;
      end else begin
         drive_sat = drive_lim[DRIVE_W-1:0];
      end

      if (inspection_drive_ff > DRIVE_FULL) begin
         insp_sat = DRIVE_FULL;
      end else if (inspection_drive_ff < -DRIVE_FULL) begin
         insp_sat = -DRIVE_FULL;
      end else begin
         insp_sat = inspection_drive_ff;
      end

      last_drive_in = inspection_mode_ff ? insp_sat : drive_sat;
   end

   // torque: drive * 100 / 16384, truncated toward zero
   always_comb begin
      torque_prod = $signed({{7{rsp_drive_ff[15]}}, rsp_drive_ff}) * 23'sd100;
      torque_adj  = torque_prod;
      if (torque_prod < 23'sd0) begin
         torque_adj = torque_prod + 23'sd16383;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.drive_value    = rsp_drive_ff;
   assign rsp_data.torque_percent = torque_adj[21:14];

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff        <= PROP_GAIN_RST;
         integ_gain_ff       <= '0;
         integral_limit_ff   <= '0;
         kickin_speed_ff     <= '0;
         reset_speed_ff      <= '0;
         max_step_ff         <= MAX_STEP_RST;
         inspection_drive_ff <= INSPECTION_DRIVE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_PROP_GAIN:        prop_gain_ff        <= csr_wdata[15:0];
            REG_INTEG_GAIN:       integ_gain_ff       <= csr_wdata[15:0];
            REG_INTEGRAL_LIMIT:   integral_limit_ff   <= csr_wdata[SUM_W-1:0];
            REG_KICKIN_SPEED:     kickin_speed_ff     <= csr_wdata[14:0];
            REG_RESET_SPEED:      reset_speed_ff      <= csr_wdata[14:0];
            REG_MAX_STEP:         max_step_ff         <= csr_wdata[14:0];
            REG_INSPECTION_DRIVE: inspection_drive_ff <= $signed(csr_wdata[15:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_flag_ff      <= 1'b0;
         motors_on_ff       <= 1'b0;
         inspection_mode_ff <= 1'b0;
         target_speed_ff    <= '0;
         measured_speed_ff  <= '0;
         have_target_ff     <= 1'b0;
         have_measured_ff   <= 1'b0;
         error_sum_ff       <= '0;
         last_drive_ff      <= '0;
      end else if (fire) begin
         case (item_ff.opcode)
            OP_READY: begin
               ready_flag_ff <= item_ff.go_ahead;
            end
            OP_STATE: begin
               inspection_mode_ff <= item_ff.is_inspection;
               if (item_ff.is_driving && ready_flag_ff) begin
                  motors_on_ff <= 1'b1;
               end
            end
            OP_TARGET: begin
               target_speed_ff <= item_ff.speed_value;
               have_target_ff  <= 1'b1;
            end
            OP_MEASURED: begin
               measured_speed_ff <= item_ff.speed_value;
               have_measured_ff  <= 1'b1;
            end
            OP_TICK: begin
               if (tick_go) begin
                  error_sum_ff  <= error_sum_in;
                  last_drive_ff <= last_drive_in;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && tick_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && tick_go) begin
         rsp_drive_ff <= last_drive_in;
      end
   end

endmodule

`default_nettype wire
